// ===== hdl/ast_pkg.sv =====
// Package for the assembler source tokenizer: state and result types, codes, character classes.
package ast_pkg;

    localparam logic [2:0] MODE_IDLE        = 3'd0;
    localparam logic [2:0] MODE_IDENT       = 3'd1;
    localparam logic [2:0] MODE_HEX         = 3'd2;
    localparam logic [2:0] MODE_COMMENT     = 3'd3;
    localparam logic [2:0] MODE_ERR_UNKNOWN = 3'd4;
    localparam logic [2:0] MODE_ERR_LARGE   = 3'd5;

    localparam logic [2:0] KIND_IDENT  = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_SYMBOL = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic ERR_UNKNOWN = 1'b0;
    localparam logic ERR_LARGE   = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CASE_GAP = 8'd32;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  held_char;
        logic        held_is_first;
        logic        crlf_pending;
        logic [7:0]  hex_accum;
        logic [15:0] line_count;
    } ast_state_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  char_value;
        logic [7:0]  number_value;
        logic        first_char;
        logic        last_char;
        logic        error_code;
        logic [15:0] line_number;
        logic        end_of_run;
    } ast_res_t;

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) ||
               c == 8'h5F || c == 8'h2E;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == 8'h3A || c == 8'h3D || c == 8'h5E || c == 8'h7E ||
               c == 8'h2A || c == CH_LF;
    endfunction

endpackage

// ===== hdl/ast_if.sv =====
// Channel interfaces: source bytes in, tokens out, start line configuration.
interface ast_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       at_end;
    modport source (output valid, src_byte, at_end, input ready);
    modport sink   (input valid, src_byte, at_end, output ready);
endinterface

interface ast_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic [7:0]  number_value;
    logic        first_char;
    logic        last_char;
    logic        error_code;
    logic [15:0] line_number;
    logic        end_of_run;
    modport source (output valid, token_kind, char_value, number_value, first_char,
                    last_char, error_code, line_number, end_of_run, input ready);
    modport sink   (input valid, token_kind, char_value, number_value, first_char,
                    last_char, error_code, line_number, end_of_run, output ready);
endinterface

interface ast_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/assembler_source_tokenizer_top.sv =====
// Assembler source tokenizer: input register, scanner step, token queue.
// The first token of a byte passes the input register and the token queue before tok.valid rises.
// Throughput: one byte per cycle when it gives at most one token and the queue has room for two;
// bytes that give two tokens go slower; the single token read port of the queue sets this.
// Reset: scanner idle, line counter 1, queue empty; a cfg beat reloads the line counter.
module assembler_source_tokenizer_top
    import ast_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ast_in_if.sink     src,
    ast_out_if.source  tok,
    ast_cfg_if.sink    cfg
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    ast_state_t st_reg;
    ast_state_t st_next;
    ast_state_t st_step;
    logic [1:0] res_n;
    ast_res_t   res0;
    ast_res_t   res1;
    ast_res_t   head;
    logic       not_empty;
    logic       room2;
    logic [2:0] q_count;
    logic       consume;
    logic       src_beat;
    logic [1:0] push_n;

    assign consume  = in_vld_reg && room2;
    assign src.ready = !in_vld_reg || consume;
    assign src_beat = src.valid && src.ready;
    assign cfg.ready = 1'b1;
    assign push_n   = consume ? res_n : 2'd0;

    always_comb
    begin
        st_next = consume ? st_step : st_reg;
        if (cfg.valid && cfg.ready)
            st_next.line_count = cfg.data;
    end

    always_ff @(posedge clk)
    begin
        if (src_beat)
        begin
            in_byte_reg <= src.src_byte;
            in_end_reg  <= src.at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= '{mode: MODE_IDLE, held_char: 8'd0, held_is_first: 1'b0,
                            crlf_pending: 1'b0, hex_accum: 8'd0, line_count: 16'd1};
        end
        else
        begin
            if (src_beat)
                in_vld_reg <= 1'b1;
            else if (consume)
                in_vld_reg <= 1'b0;
            st_reg <= st_next;
        end
    end

    ast_core u_core (
        .st       (st_reg),
        .src_byte (in_byte_reg),
        .at_end   (in_end_reg),
        .st_next  (st_step),
        .res_n    (res_n),
        .res0     (res0),
        .res1     (res1)
    );

    ast_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .din0      (res0),
        .din1      (res1),
        .pop       (tok.ready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2),
        .count     (q_count)
    );

    assign tok.valid        = not_empty;
    assign tok.token_kind   = head.token_kind;
    assign tok.char_value   = head.char_value;
    assign tok.number_value = head.number_value;
    assign tok.first_char   = head.first_char;
    assign tok.last_char    = head.last_char;
    assign tok.error_code   = head.error_code;
    assign tok.line_number  = head.line_number;
    assign tok.end_of_run   = head.end_of_run;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 3'd4)
        else $error("token queue over capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> q_count <= 3'd2)
        else $error("token push without room");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !consume |=> in_vld_reg && $stable(in_byte_reg))
        else $error("held byte lost");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mode == MODE_ERR_UNKNOWN || st_reg.mode == MODE_ERR_LARGE)
        |=> $stable(st_reg.mode))
        else $error("error state left before reset");

endmodule

// ===== hdl/ast_core.sv =====
// Scanner step: next state and up to two tokens for one source byte.
module ast_core
    import ast_pkg::*;
(
    input  ast_state_t  st,
    input  logic [7:0]  src_byte,
    input  logic        at_end,
    output ast_state_t  st_next,
    output logic [1:0]  res_n,
    output ast_res_t    res0,
    output ast_res_t    res1
);

    ast_res_t   a;
    ast_res_t   b;
    logic       a_vld;
    logic       b_vld;
    logic       skip;
    logic       go;
    logic [7:0] c;
    logic [3:0] dig;

    always_comb
    begin
        st_next = st;
        a       = '0;
        b       = '0;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        skip    = 1'b0;
        go      = 1'b0;
        c       = CH_NUL;
        dig     = 4'd0;
        a.line_number = st.line_count;

        if (st.mode == MODE_ERR_UNKNOWN || st.mode == MODE_ERR_LARGE)
        begin
            a_vld        = 1'b1;
            a.token_kind = KIND_ERROR;
            a.error_code = (st.mode == MODE_ERR_LARGE) ? ERR_LARGE : ERR_UNKNOWN;
        end
        else
        begin
            st_next.crlf_pending = 1'b0;
            if (at_end)
                c = CH_NUL;
            else if (src_byte == CH_LF && st.crlf_pending)
                skip = 1'b1;
            else if (src_byte == CH_CR)
            begin
                st_next.crlf_pending = 1'b1;
                c = CH_LF;
            end
            else if (src_byte >= 8'h61 && src_byte <= 8'h7A)
                c = src_byte - CASE_GAP;
            else
                c = src_byte;

            dig = 4'((c <= 8'h39) ? c - 8'h30 : c - 8'd55);

            if (!skip)
            begin
                go = 1'b1;
                case (st.mode)
                    MODE_IDENT:
                    begin
                        a_vld        = 1'b1;
                        a.token_kind = KIND_IDENT;
                        a.char_value = st.held_char;
                        a.first_char = st.held_is_first;
                        if (is_ident(c))
                        begin
                            st_next.held_char     = c;
                            st_next.held_is_first = 1'b0;
                            go = 1'b0;
                        end
                        else
                        begin
                            a.last_char  = 1'b1;
                            st_next.mode = MODE_IDLE;
                        end
                    end
                    MODE_HEX:
                    begin
                        if (is_hex(c))
                        begin
                            go = 1'b0;
                            if (st.hex_accum > 8'h0F)
                            begin
                                st_next.mode = MODE_ERR_LARGE;
                                a_vld        = 1'b1;
                                a.token_kind = KIND_ERROR;
                                a.error_code = ERR_LARGE;
                            end
                            else
                                st_next.hex_accum = {st.hex_accum[3:0], dig};
                        end
                        else
                        begin
                            a_vld          = 1'b1;
                            a.token_kind   = KIND_NUMBER;
                            a.number_value = st.hex_accum;
                            st_next.mode   = MODE_IDLE;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (c != CH_LF && c != CH_NUL)
                            go = 1'b0;
                        else
                            st_next.mode = MODE_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (go)
            begin
                if (c == CH_SPACE || c == CH_TAB)
                begin
                end
                else if (c == CH_SEMI)
                    st_next.mode = MODE_COMMENT;
                else if (is_ident(c))
                begin
                    st_next.held_char     = c;
                    st_next.held_is_first = 1'b1;
                    st_next.mode          = MODE_IDENT;
                end
                else if (c == CH_HASH)
                begin
                    st_next.hex_accum = 8'd0;
                    st_next.mode      = MODE_HEX;
                end
                else if (is_symbol(c))
                begin
                    if (c == CH_LF)
                        st_next.line_count = st.line_count + 16'd1;
                    b_vld        = 1'b1;
                    b.token_kind = KIND_SYMBOL;
                    b.char_value = c;
                end
                else if (c == CH_NUL)
                begin
                    b_vld        = 1'b1;
                    b.token_kind = KIND_END;
                end
                else
                begin
                    st_next.mode = MODE_ERR_UNKNOWN;
                    b_vld        = 1'b1;
                    b.token_kind = KIND_ERROR;
                    b.error_code = ERR_UNKNOWN;
                end
            end
        end
        b.line_number = st_next.line_count;

        res_n = {1'b0, a_vld} + {1'b0, b_vld};
        res0  = a_vld ? a : b;
        res1  = b;
        res0.end_of_run = (res_n == 2'd1);
        res1.end_of_run = 1'b1;
    end

endmodule

// ===== hdl/ast_fifo.sv =====
// Four-entry token queue: up to two writes and one read per cycle.
module ast_fifo
    import ast_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  ast_res_t   din0,
    input  ast_res_t   din1,
    input  logic       pop,
    output ast_res_t   head,
    output logic       not_empty,
    output logic       room2,
    output logic [2:0] count
);

    ast_res_t   mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_pop;

    assign do_pop      = pop && (count_reg != 3'd0);
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b0, do_pop};

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= din0;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= din1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign room2     = (count_reg <= 3'd2);
    assign count     = count_reg;

endmodule

// ===== test/tb_assembler_source_tokenizer_top.sv =====
// Testbench for the assembler source tokenizer: random source text, token prediction and checking.
module tb_assembler_source_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 94;
    localparam int HOLD_CYCLES    = 200;
    localparam int STICKY_ITEMS   = 12;

    class token_scoreboard;
        logic [15:0] start_line;
        logic [2:0]  mode;
        logic [7:0]  held_char;
        logic        held_is_first;
        logic        crlf_pending;
        logic [7:0]  hex_accum;
        logic [15:0] line_count;
        ast_res_t    step_q[$];
        ast_res_t    expected_q[$];
        int          errors;

        function new();
            start_line    = 16'd1;
            mode          = MODE_IDLE;
            held_char     = 8'd0;
            held_is_first = 1'b0;
            crlf_pending  = 1'b0;
            hex_accum     = 8'd0;
            line_count    = 16'd1;
            errors        = 0;
        endfunction

        function logic [7:0] upper_case(input logic [7:0] c);
            return (c >= "a" && c <= "z") ? c - CASE_GAP : c;
        endfunction

        function logic ident_char(input logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_" || c == ".";
        endfunction

        function logic hex_char(input logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
        endfunction

        function logic symbol_char(input logic [7:0] c);
            return c == ":" || c == "=" || c == "^" || c == "~" || c == "*" || c == CH_LF;
        endfunction

        function void add_token(input logic [2:0] kind, input logic [7:0] ch,
                                input logic [7:0] num, input logic first,
                                input logic last, input logic code);
            ast_res_t t;
            t.token_kind   = kind;
            t.char_value   = ch;
            t.number_value = num;
            t.first_char   = first;
            t.last_char    = last;
            t.error_code   = code;
            t.line_number  = line_count;
            t.end_of_run   = 1'b0;
            step_q.push_back(t);
        endfunction

        function void load_start_line(input logic [15:0] value);
            start_line = value;
            line_count = value;
        endfunction

        function void scan_char(input logic [7:0] c);
            logic       go_on;
            logic [3:0] digit;
            go_on = 1'b1;
            case (mode)
                MODE_IDENT:
                    if (ident_char(c)) begin
                        add_token(KIND_IDENT, held_char, 8'd0, held_is_first, 1'b0, 1'b0);
                        held_char     = c;
                        held_is_first = 1'b0;
                        go_on         = 1'b0;
                    end
                    else begin
                        add_token(KIND_IDENT, held_char, 8'd0, held_is_first, 1'b1, 1'b0);
                        mode = MODE_IDLE;
                    end
                MODE_HEX:
                    if (hex_char(c)) begin
                        go_on = 1'b0;
                        digit = 4'((c <= "9") ? c - "0" : c - "A" + 8'd10);
                        if (hex_accum > 8'h0F) begin
                            mode = MODE_ERR_LARGE;
                            add_token(KIND_ERROR, 8'd0, 8'd0, 1'b0, 1'b0, ERR_LARGE);
                        end
                        else
                            hex_accum = {hex_accum[3:0], digit};
                    end
                    else begin
                        add_token(KIND_NUMBER, 8'd0, hex_accum, 1'b0, 1'b0, 1'b0);
                        mode = MODE_IDLE;
                    end
                MODE_COMMENT:
                    if (c != CH_LF && c != CH_NUL)
                        go_on = 1'b0;
                    else
                        mode = MODE_IDLE;
                default:
                    go_on = 1'b1;
            endcase
            if (go_on) begin
                if (c == CH_SEMI)
                    mode = MODE_COMMENT;
                else if (ident_char(c)) begin
                    held_char     = c;
                    held_is_first = 1'b1;
                    mode          = MODE_IDENT;
                end
                else if (c == CH_HASH) begin
                    hex_accum = 8'd0;
                    mode      = MODE_HEX;
                end
                else if (symbol_char(c)) begin
                    if (c == CH_LF)
                        line_count = line_count + 16'd1;
                    add_token(KIND_SYMBOL, c, 8'd0, 1'b0, 1'b0, 1'b0);
                end
                else if (c == CH_NUL)
                    add_token(KIND_END, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
                else if (c != CH_SPACE && c != CH_TAB) begin
                    mode = MODE_ERR_UNKNOWN;
                    add_token(KIND_ERROR, 8'd0, 8'd0, 1'b0, 1'b0, ERR_UNKNOWN);
                end
            end
        endfunction

        function void note_byte(input logic [7:0] raw, input logic ends);
            ast_res_t t;
            step_q.delete();
            if (mode == MODE_ERR_UNKNOWN || mode == MODE_ERR_LARGE)
                add_token(KIND_ERROR, 8'd0, 8'd0, 1'b0, 1'b0,
                          (mode == MODE_ERR_LARGE) ? ERR_LARGE : ERR_UNKNOWN);
            else if (ends) begin
                crlf_pending = 1'b0;
                scan_char(CH_NUL);
            end
            else if (raw == CH_LF && crlf_pending)
                crlf_pending = 1'b0;
            else begin
                crlf_pending = (raw == CH_CR);
                scan_char((raw == CH_CR) ? CH_LF : upper_case(raw));
            end
            foreach (step_q[i]) begin
                t            = step_q[i];
                t.end_of_run = (i == step_q.size() - 1);
                expected_q.push_back(t);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_token(input ast_res_t got);
            ast_res_t want;
            if (expected_q.size() == 0) begin
                $error("token_kind: expected none, got %0d", got.token_kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
            check_field("char_value", 16'(want.char_value), 16'(got.char_value));
            check_field("number_value", 16'(want.number_value), 16'(got.number_value));
            check_field("first_char", 16'(want.first_char), 16'(got.first_char));
            check_field("last_char", 16'(want.last_char), 16'(got.last_char));
            check_field("error_code", 16'(want.error_code), 16'(got.error_code));
            check_field("line_number", want.line_number, got.line_number);
            check_field("end_of_run", 16'(want.end_of_run), 16'(got.end_of_run));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ast_in_if  src_bus ();
    ast_out_if tok_bus ();
    ast_cfg_if cfg_bus ();

    token_scoreboard sb;
    int unsigned     src_idle_pct;
    int unsigned     sink_stall_pct;
    int              hold_request;
    int              hold_left;
    int              quiet_cycles;

    assembler_source_tokenizer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_bus),
        .tok   (tok_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin : token_sink
        ast_res_t got;
        if (rst_n && tok_bus.valid && tok_bus.ready) begin
            got.token_kind   = tok_bus.token_kind;
            got.char_value   = tok_bus.char_value;
            got.number_value = tok_bus.number_value;
            got.first_char   = tok_bus.first_char;
            got.last_char    = tok_bus.last_char;
            got.error_code   = tok_bus.error_code;
            got.line_number  = tok_bus.line_number;
            got.end_of_run   = tok_bus.end_of_run;
            sb.check_token(got);
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            tok_bus.ready <= 1'b0;
        end
        else
            tok_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((src_bus.valid && src_bus.ready) || (tok_bus.valid && tok_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_beat(input logic [7:0] value, input logic ends);
        while ($urandom_range(99) < src_idle_pct) begin
            src_bus.valid <= 1'b0;
            @(posedge clk);
        end
        src_bus.valid    <= 1'b1;
        src_bus.src_byte <= value;
        src_bus.at_end   <= ends;
        @(posedge clk);
        while (!src_bus.ready)
            @(posedge clk);
        sb.note_byte(value, ends);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_beat(text[i], 1'b0);
    endtask

    task automatic wait_drained();
        src_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_line(input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        sb.load_start_line(value);
    endtask

    // Mostly well-formed source text; never errors, so the sticky error is left to the end.
    function automatic void pick_source_byte(output logic [7:0] value, output logic ends);
        string       symbols   = ":=^~*";
        string       hex_chars = "0123456789ABCDEFabcdef";
        int unsigned r;
        r     = $urandom_range(99);
        ends  = 1'b0;
        value = CH_SPACE;
        if (sb.crlf_pending && r < 40)
            value = CH_LF;
        else if (sb.mode == MODE_COMMENT) begin
            if (r < 12)
                value = $urandom_range(1) ? CH_CR : CH_LF;
            else
                value = 8'($urandom_range(255));
        end
        else if (sb.mode == MODE_HEX && sb.hex_accum <= 8'h0F && r < 45)
            value = hex_chars[$urandom_range(21)];
        else if (r < 30)
            value = 8'(($urandom_range(1) ? "A" : "a") + $urandom_range(25));
        else if (r < 40)
            value = 8'("0" + $urandom_range(9));
        else if (r < 44)
            value = $urandom_range(1) ? "_" : ".";
        else if (r < 54)
            value = $urandom_range(1) ? CH_SPACE : CH_TAB;
        else if (r < 64)
            value = symbols[$urandom_range(4)];
        else if (r < 71)
            value = CH_HASH;
        else if (r < 75)
            value = CH_SEMI;
        else if (r < 88)
            value = $urandom_range(1) ? CH_CR : CH_LF;
        else begin
            ends  = 1'($urandom_range(1));
            value = ends ? 8'($urandom_range(255)) : CH_NUL;
        end
        if (!ends && sb.mode == MODE_HEX && sb.hex_accum > 8'h0F &&
            sb.hex_char(sb.upper_case(value)))
            value = CH_SPACE;
    endfunction

    initial
    begin
        logic [7:0]  value;
        logic        ends;
        logic [15:0] start_lines [4];
        int unsigned idle_by_phase [4];
        int unsigned stall_by_phase [4];

        sb               = new();
        rst_n            = 1'b0;
        src_bus.valid    = 1'b0;
        src_bus.src_byte = 8'd0;
        src_bus.at_end   = 1'b0;
        tok_bus.ready    = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = 16'd0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        hold_request     = 0;
        hold_left        = 0;
        quiet_cycles     = 0;

        start_lines    = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
        idle_by_phase  = '{0, 83, 0, 21};
        stall_by_phase = '{0, 0, 83, 21};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every token kind but error, case folding, comment with odd bytes, CR LF, bare CR
        send_text("a_.Z9 #fF:#=^~*\t;");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat("z", 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_NUL, 1'b0);
        send_beat(8'hA5, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_start_line(start_lines[p]);
            src_idle_pct   = idle_by_phase[p];
            sink_stall_pct = stall_by_phase[p];
            if (p == 0)
                hold_request = HOLD_CYCLES;
            repeat (PHASE_ITEMS) begin
                pick_source_byte(value, ends);
                send_beat(value, ends);
            end
        end

        // sticky error: either an unknown byte or an oversized hex literal
        wait_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_beat(CH_LF, 1'b0);
        if ($urandom_range(1))
            send_text("#FFF");
        else begin
            value = 8'($urandom_range(1) ? $urandom_range(128, 255) : $urandom_range(1, 8));
            send_beat(value, 1'b0);
        end
        repeat (STICKY_ITEMS) begin
            value = 8'($urandom_range(255));
            ends  = 1'($urandom_range(1));
            send_beat(value, ends);
        end
        wait_drained();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
